>>> rtl/fvn_pkg.sv
// Shared constants, types and the permutation ROM for the fractal value noise unit.
`default_nettype none
package fvn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int WFB = 16;

    localparam int PT_W = 32;
    localparam int FREQ_W = 20;
    localparam int OCT_W = 4;
    localparam int SEED_W = 8;
    localparam int NOISE_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;

    localparam int COORD_W = 24;
    localparam int FRAC_W = 16;
    localparam int LAT_W = 8;
    localparam int DEPTH_W = $clog2(MAX_OCTAVES + 1);
    localparam int OCT_IDX_W = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

    localparam int WT_W = WFB + 2;
    localparam int LOW_W = WFB + 12;
    localparam int V_W = 2 * WFB + 16;
    localparam int N_W = 64 - WFB;
    localparam int ACC_W = 64;
    localparam int DEN_W = MAX_OCTAVES;
    localparam int TQ_W = NOISE_W + MAX_OCTAVES;
    localparam int RK = TQ_W;
    localparam int RW = RK + 1;
    localparam int NPAIR = (MAX_OCTAVES + 1) / 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQUENCY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd2;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 20'd6554;
    localparam logic [OCT_W-1:0] OCT_RESET = 4'd8;
    localparam logic [SEED_W-1:0] SEED_RESET = 8'd0;

    typedef logic [LAT_W-1:0] t_byte;
    typedef logic [N_W-1:0] t_noise_term;

    localparam t_byte PERM_ROM [256] = '{
        8'd208, 8'd34, 8'd231, 8'd213, 8'd32, 8'd248, 8'd233, 8'd56, 8'd161, 8'd78, 8'd24,
        8'd140, 8'd71, 8'd48, 8'd140, 8'd254, 8'd245, 8'd255, 8'd247, 8'd247, 8'd40,
        8'd185, 8'd248, 8'd251, 8'd245, 8'd28, 8'd124, 8'd204, 8'd204, 8'd76, 8'd36, 8'd1,
        8'd107, 8'd28, 8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128, 8'd167, 8'd204,
        8'd9, 8'd92, 8'd217, 8'd54, 8'd239, 8'd174, 8'd173, 8'd102, 8'd193, 8'd189, 8'd190,
        8'd121, 8'd100, 8'd108, 8'd167, 8'd44, 8'd43, 8'd77, 8'd180, 8'd204, 8'd8, 8'd81,
        8'd70, 8'd223, 8'd11, 8'd38, 8'd24, 8'd254, 8'd210, 8'd210, 8'd177, 8'd32, 8'd81,
        8'd195, 8'd243, 8'd125, 8'd8, 8'd169, 8'd112, 8'd32, 8'd97, 8'd53, 8'd195, 8'd13,
        8'd203, 8'd9, 8'd47, 8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
        8'd181, 8'd235, 8'd193, 8'd206, 8'd70, 8'd180, 8'd174, 8'd0, 8'd167, 8'd181, 8'd41,
        8'd164, 8'd30, 8'd116, 8'd127, 8'd198, 8'd245, 8'd146, 8'd87, 8'd224, 8'd149,
        8'd206, 8'd57, 8'd4, 8'd192, 8'd210, 8'd65, 8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
        8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40, 8'd35, 8'd195, 8'd38, 8'd58, 8'd65,
        8'd207, 8'd215, 8'd253, 8'd65, 8'd85, 8'd208, 8'd76, 8'd62, 8'd3, 8'd237, 8'd55,
        8'd89, 8'd232, 8'd50, 8'd217, 8'd64, 8'd244, 8'd157, 8'd199, 8'd121, 8'd252, 8'd90,
        8'd17, 8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187, 8'd234, 8'd177, 8'd73,
        8'd174, 8'd193, 8'd100, 8'd192, 8'd143, 8'd97, 8'd53, 8'd145, 8'd135, 8'd19,
        8'd103, 8'd13, 8'd90, 8'd135, 8'd151, 8'd199, 8'd91, 8'd239, 8'd247, 8'd33, 8'd39,
        8'd145, 8'd101, 8'd120, 8'd99, 8'd3, 8'd186, 8'd86, 8'd99, 8'd41, 8'd237, 8'd203,
        8'd111, 8'd79, 8'd220, 8'd135, 8'd158, 8'd42, 8'd30, 8'd154, 8'd120, 8'd67, 8'd87,
        8'd167, 8'd135, 8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21, 8'd233,
        8'd58, 8'd129, 8'd233, 8'd142, 8'd39, 8'd128, 8'd211, 8'd118, 8'd137, 8'd139,
        8'd255, 8'd114, 8'd20, 8'd218, 8'd113, 8'd154, 8'd27, 8'd127, 8'd246, 8'd250, 8'd1,
        8'd8, 8'd198, 8'd250, 8'd209, 8'd92, 8'd222, 8'd173, 8'd21, 8'd88, 8'd102, 8'd219
    };

    function automatic logic [WFB-1:0] to_wfrac(input logic [FRAC_W-1:0] f);
        logic [WFB+FRAC_W-1:0] tmp;
        tmp = {f, {WFB{1'b0}}};
        return tmp[WFB+FRAC_W-1:FRAC_W];
    endfunction

endpackage
`default_nettype wire

>>> rtl/fvn_lane.sv
// One octave of value noise: lattice hash, smoothstep weights and bilinear blend.
`default_nettype none
module fvn_lane (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  wire  [fvn_pkg::COORD_W-1:0]    i_cx,
    input  wire  [fvn_pkg::COORD_W-1:0]    i_cy,
    input  wire  [fvn_pkg::SEED_W-1:0]     i_seed,
    output logic [fvn_pkg::N_W-1:0]        o_n
);
    import fvn_pkg::*;

    t_byte               r_ix;
    t_byte               r_rowa;
    t_byte               r_rowb;
    logic [WFB-1:0]      r_sx;
    logic [WFB-1:0]      r_sy;
    logic [WFB-1:0]      r_s2x;
    logic [WFB-1:0]      r_s2y;

    logic [WT_W-1:0]     r_wx;
    logic [WT_W-1:0]     r_wy3;
    t_byte               r_c00;
    t_byte               r_c10;
    t_byte               r_c01;
    t_byte               r_c11;

    logic signed [LOW_W-1:0] r_lo;
    logic signed [LOW_W-1:0] r_hi;
    logic [WT_W-1:0]     r_wy4;

    logic [N_W-1:0]      r_n;

    logic [WFB-1:0]      sx;
    logic [WFB-1:0]      sy;
    t_byte               iy;
    logic [2*WFB-1:0]    sqx;
    logic [2*WFB-1:0]    sqy;
    logic [WFB+1:0]      fx;
    logic [WFB+1:0]      fy;
    logic [2*WFB+1:0]    wpx;
    logic [2*WFB+1:0]    wpy;
    t_byte               ix1;

    logic signed [LAT_W:0]   dlo;
    logic signed [LAT_W:0]   dhi;
    logic signed [WT_W:0]    wxs;
    logic signed [LOW_W-1:0] plo;
    logic signed [LOW_W-1:0] phi;
    logic signed [LOW_W-1:0] blo;
    logic signed [LOW_W-1:0] bhi;

    logic signed [LOW_W:0]   dhl;
    logic signed [WT_W:0]    wys;
    logic signed [V_W-1:0]   pv;
    logic signed [V_W-1:0]   bv;
    logic signed [V_W-1:0]   v;
    logic signed [V_W-WFB-1:0] vs;

    always_comb begin
        sx  = to_wfrac(i_cx[FRAC_W-1:0]);
        sy  = to_wfrac(i_cy[FRAC_W-1:0]);
        iy  = i_cy[COORD_W-1:FRAC_W] + i_seed;
        sqx = sx * sx;
        sqy = sy * sy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ix   <= i_cx[COORD_W-1:FRAC_W];
            r_rowa <= PERM_ROM[iy];
            r_rowb <= PERM_ROM[iy + 8'd1];
            r_sx   <= sx;
            r_sy   <= sy;
            r_s2x  <= sqx[2*WFB-1:WFB];
            r_s2y  <= sqy[2*WFB-1:WFB];
        end
    end

    always_comb begin
        fx  = (WFB+2)'(3) << WFB;
        fx  = fx - {1'b0, r_sx, 1'b0};
        fy  = (WFB+2)'(3) << WFB;
        fy  = fy - {1'b0, r_sy, 1'b0};
        wpx = r_s2x * fx;
        wpy = r_s2y * fy;
        ix1 = r_ix + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx  <= wpx[2*WFB+1:WFB];
            r_wy3 <= wpy[2*WFB+1:WFB];
            r_c00 <= PERM_ROM[r_rowa + r_ix];
            r_c10 <= PERM_ROM[r_rowa + ix1];
            r_c01 <= PERM_ROM[r_rowb + r_ix];
            r_c11 <= PERM_ROM[r_rowb + ix1];
        end
    end

    always_comb begin
        dlo = $signed({1'b0, r_c10}) - $signed({1'b0, r_c00});
        dhi = $signed({1'b0, r_c11}) - $signed({1'b0, r_c01});
        wxs = $signed({1'b0, r_wx});
        plo = dlo * wxs;
        phi = dhi * wxs;
        blo = $signed({{(LOW_W-LAT_W-WFB){1'b0}}, r_c00, {WFB{1'b0}}});
        bhi = $signed({{(LOW_W-LAT_W-WFB){1'b0}}, r_c01, {WFB{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= blo + plo;
            r_hi  <= bhi + phi;
            r_wy4 <= r_wy3;
        end
    end

    always_comb begin
        dhl = $signed({r_hi[LOW_W-1], r_hi}) - $signed({r_lo[LOW_W-1], r_lo});
        wys = $signed({1'b0, r_wy4});
        pv  = dhl * wys;
        bv  = $signed({{(V_W-LOW_W-WFB){r_lo[LOW_W-1]}}, r_lo, {WFB{1'b0}}});
        v   = bv + pv;
        vs  = v[V_W-1:WFB];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= {{(N_W-(V_W-WFB)){vs[V_W-WFB-1]}}, vs};
        end
    end

    assign o_n = r_n;

endmodule
`default_nettype wire

>>> rtl/fvn_norm.sv
// Weighted octave sum and normalization by the per-depth amplitude total.
`default_nettype none
module fvn_norm (
    input  wire                            i_clk,
    input  wire                            i_en,
    input  wire  [fvn_pkg::DEPTH_W-1:0]    i_depth,
    input  wire  [fvn_pkg::N_W-1:0]        i_n [fvn_pkg::MAX_OCTAVES],
    output logic [fvn_pkg::NOISE_W-1:0]    o_noise_value
);
    import fvn_pkg::*;

    logic [RW-1:0]          recip [MAX_OCTAVES];

    for (genvar d = 1; d <= MAX_OCTAVES; d++) begin : g_recip
        localparam logic [RW-1:0] RV = RW'((64'd1 << RK) / ((64'd1 << d) - 64'd1));
        assign recip[d-1] = RV;
    end

    logic [ACC_W-1:0]       r_pair [NPAIR];
    logic [DEPTH_W-1:0]     r_depth6;
    logic [ACC_W-1:0]       r_acc;
    logic [DEPTH_W-1:0]     r_depth7;
    logic                   r_sat;
    logic [TQ_W-1:0]        r_tl;
    logic [DEN_W-1:0]       r_den;
    logic [TQ_W+RW-1:0]     r_prod;
    logic [NOISE_W-1:0]     r_q;

    logic [ACC_W-1:0]       term [MAX_OCTAVES];
    logic [ACC_W-1:0]       acc;
    logic [DEPTH_W-1:0]     sh;
    logic [ACC_W-WFB+7:0]   t;
    logic [DEN_W-1:0]       den;
    logic [DEPTH_W-1:0]     dm1;
    logic [TQ_W:0]          q0;
    logic [TQ_W+DEN_W:0]    qd;
    logic [TQ_W+DEN_W:0]    rem;
    logic [TQ_W:0]          q;

    always_comb begin
        for (int i = 0; i < MAX_OCTAVES; i++) begin
            sh = i_depth - DEPTH_W'(i + 1);
            if (DEPTH_W'(i) < i_depth) begin
                term[i] = {{(ACC_W-N_W){1'b0}}, i_n[i]} << sh;
            end else begin
                term[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NPAIR; j++) begin
                if (2 * j + 1 < MAX_OCTAVES) begin
                    r_pair[j] <= term[2*j] + term[2*j+1];
                end else begin
                    r_pair[j] <= term[2*j];
                end
            end
            r_depth6 <= i_depth;
        end
    end

    always_comb begin
        acc = '0;
        for (int j = 0; j < NPAIR; j++) begin
            acc = acc + r_pair[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc    <= acc;
            r_depth7 <= r_depth6;
        end
    end

    always_comb begin
        t   = r_acc[ACC_W-1:WFB-8];
        den = DEN_W'(({{DEN_W{1'b0}}, 1'b1} << r_depth7) - 1'b1);
        dm1 = r_depth7 - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat  <= t >= (ACC_W-WFB+8)'({den, {NOISE_W{1'b0}}});
            r_tl   <= t[TQ_W-1:0];
            r_den  <= den;
            r_prod <= t[TQ_W-1:0] * recip[dm1[OCT_IDX_W-1:0]];
        end
    end

    always_comb begin
        q0  = r_prod[TQ_W+RW-1:RK];
        qd  = q0 * r_den;
        rem = {{(DEN_W+1){1'b0}}, r_tl} - qd;
        q   = (rem >= {{(TQ_W+1){1'b0}}, r_den}) ? q0 + 1'b1 : q0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_sat ? {NOISE_W{1'b1}} : q[NOISE_W-1:0];
        end
    end

    assign o_noise_value = r_q;

endmodule
`default_nettype wire

>>> rtl/fractal_value_noise_2d_unit.sv
// Top level of the fractal value noise unit: configuration, scaling, lanes and control.
// Accepts one point per clock while o_stall is low. Each point is scaled and registered,
// then runs through the per-octave lanes (one lane per octave, all in parallel), after
// which the octaves are summed and divided by the amplitude total. A stalled output
// freezes the whole pipeline, so o_stall follows i_stall while a result waits.
`default_nettype none
module fractal_value_noise_2d_unit (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire  [fvn_pkg::PT_W-1:0]           i_point_x,
    input  wire  [fvn_pkg::PT_W-1:0]           i_point_y,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic [fvn_pkg::NOISE_W-1:0]        o_noise_value,
    input  wire                                i_cfg_we,
    input  wire  [fvn_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [fvn_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import fvn_pkg::*;

    localparam int NSTG = 9;
    localparam int LANE_STG = 4;

    logic [FREQ_W-1:0]     r_freq;
    logic [OCT_W-1:0]      r_oct;
    logic [SEED_W-1:0]     r_seed;
    logic [NSTG-1:0]       r_vld;
    logic [COORD_W-1:0]    r_cx;
    logic [COORD_W-1:0]    r_cy;
    logic [DEPTH_W-1:0]    r_dpipe [LANE_STG+1];

    logic                  en;
    logic [PT_W+FREQ_W-1:0] px;
    logic [PT_W+FREQ_W-1:0] py;
    logic [DEPTH_W-1:0]    depth;
    logic [N_W-1:0]        lane_n [MAX_OCTAVES];

    assign en      = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RESET;
            r_oct  <= OCT_RESET;
            r_seed <= SEED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FREQUENCY: r_freq <= i_cfg_wdata[FREQ_W-1:0];
                CFG_OCTAVES:   r_oct  <= i_cfg_wdata[OCT_W-1:0];
                CFG_SEED:      r_seed <= i_cfg_wdata[SEED_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_comb begin
        px = i_point_x * r_freq;
        py = i_point_y * r_freq;
        if (r_oct == '0) begin
            depth = DEPTH_W'(1);
        end else if ({{DEPTH_W{1'b0}}, r_oct} > (DEPTH_W+OCT_W)'(MAX_OCTAVES)) begin
            depth = DEPTH_W'(MAX_OCTAVES);
        end else begin
            depth = DEPTH_W'(r_oct);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cx       <= px[COORD_W+FRAC_W-1:FRAC_W];
            r_cy       <= py[COORD_W+FRAC_W-1:FRAC_W];
            r_dpipe[0] <= depth;
            for (int k = 1; k <= LANE_STG; k++) begin
                r_dpipe[k] <= r_dpipe[k-1];
            end
        end
    end

    for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_lane
        fvn_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_cx   (COORD_W'(r_cx << i)),
            .i_cy   (COORD_W'(r_cy << i)),
            .i_seed (r_seed),
            .o_n    (lane_n[i])
        );
    end

    fvn_norm u_norm (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_depth       (r_dpipe[LANE_STG]),
        .i_n           (lane_n),
        .o_noise_value (o_noise_value)
    );

endmodule
`default_nettype wire
